### sv/mbm_pkg.sv
// mbm_pkg: types, register decode codes and bank constants for the bank mapper
// no dependencies; imported by every module of multicart_bank_mapper_irq
package mbm_pkg;

  localparam int unsigned NumSlots  = 12;
  localparam int unsigned PrgSlots  = 4;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned BankW     = 9;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [SlotW-1:0] LAST_PRG_SLOT = SlotW'(PrgSlots - 1);
  localparam logic [SlotW-1:0] LAST_CHR_SLOT = SlotW'(NumSlots - 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [15:0] OUTER_ADDR = 16'h6000;
  localparam logic [15:0] ADDR_MASK  = 16'hE001;

  localparam logic [15:0] REG_MODE       = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA  = 16'h8001;
  localparam logic [15:0] REG_MIRROR     = 16'hA000;
  localparam logic [15:0] REG_OUTER      = 16'hA001;
  localparam logic [15:0] REG_IRQ_COUNT  = 16'hC000;
  localparam logic [15:0] REG_IRQ_RELOAD = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON     = 16'hE001;

  localparam logic [CfgIndexW-1:0] CFG_PATCH_MODE = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_CHR_ROM    = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_FOUR_SCR   = 2'd2;

  localparam int unsigned MODE_PRG_SWAP_BIT = 6;
  localparam int unsigned MODE_CHR_SWAP_BIT = 7;

  localparam logic [2:0] OUTER_MAX     = 3'd7;
  localparam logic [2:0] OUTER_CLAMP   = 3'd6;
  localparam logic [2:0] OUTER_PATCH_X = 3'd2;

  localparam logic [7:0] FIX_PATCH  = 8'd6;
  localparam logic [7:0] FIX_NORMAL = 8'd14;
  localparam logic [8:0] CHR_HIGH_BASE = 9'd128;

  typedef enum logic [2:0] {
    SEL_CHR_PAIR0,
    SEL_CHR_PAIR1,
    SEL_CHR_SINGLE0,
    SEL_CHR_SINGLE1,
    SEL_CHR_SINGLE2,
    SEL_CHR_SINGLE3,
    SEL_PRG_FIRST,
    SEL_PRG_SECOND
  } bank_sel_e;

  typedef logic [BankW-1:0] bank_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        line_counts;
  } item_t;

  typedef struct packed {
    logic patch_mode;
    logic chr_rom_present;
    logic four_screen;
  } cfg_t;

  typedef struct packed {
    bank_t [NumSlots-1:0] bank;
    logic                 mirror;
    logic                 irq;
    logic                 chr_on;
  } frame_t;

endpackage

### sv/mbm_regs.sv
// mbm_regs: mapper register file, scanline irq counter and window bank calculation
// depends on mbm_pkg; feeds a frame of window banks to mbm_emit
module mbm_regs
  import mbm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  item_t  item_i,
  input  cfg_t   cfg_i,
  output frame_t frame_o
);

  logic [7:0] mode_q, mode_d;
  logic [2:0] outer_q, outer_d;
  logic [7:0] prg_first_q, prg_first_d;
  logic [7:0] prg_second_q, prg_second_d;
  logic [7:0] pair_q [2], pair_d [2];
  logic [7:0] single_q [4], single_d [4];
  logic       mirror_q, mirror_d;
  logic       irq_en_q, irq_en_d;
  logic [7:0] irq_cnt_q, irq_cnt_d;
  logic [7:0] irq_rel_q, irq_rel_d;
  logic       irq_line_q, irq_line_d;

  always_comb begin
    logic [7:0] dec;
    dec          = irq_cnt_q - 8'd1;
    mode_d       = mode_q;
    outer_d      = outer_q;
    prg_first_d  = prg_first_q;
    prg_second_d = prg_second_q;
    pair_d       = pair_q;
    single_d     = single_q;
    mirror_d     = mirror_q;
    irq_en_d     = irq_en_q;
    irq_cnt_d    = irq_cnt_q;
    irq_rel_d    = irq_rel_q;
    irq_line_d   = irq_line_q;
    if (item_i.cmd == CMD_TICK) begin
      if (item_i.line_counts && irq_en_q) begin
        if (dec == 8'd0) begin
          irq_cnt_d  = irq_rel_q;
          irq_line_d = 1'b1;
        end else begin
          irq_cnt_d = dec;
        end
      end
    end else if (!item_i.bus_address[15]) begin
      if (item_i.bus_address == OUTER_ADDR) begin
        outer_d = cfg_i.patch_mode ? {1'b0, item_i.bus_data[2:1]}
                                   : {1'b0, item_i.bus_data[0], 1'b0};
      end
    end else begin
      case (item_i.bus_address & ADDR_MASK)
        REG_MODE: begin
          mode_d = item_i.bus_data;
        end
        REG_BANK_DATA: begin
          case (bank_sel_e'(mode_q[2:0]))
            SEL_CHR_PAIR0:   pair_d[0]   = {item_i.bus_data[7:1], 1'b0};
            SEL_CHR_PAIR1:   pair_d[1]   = {item_i.bus_data[7:1], 1'b0};
            SEL_CHR_SINGLE0: single_d[0] = item_i.bus_data;
            SEL_CHR_SINGLE1: single_d[1] = item_i.bus_data;
            SEL_CHR_SINGLE2: single_d[2] = item_i.bus_data;
            SEL_CHR_SINGLE3: single_d[3] = item_i.bus_data;
            SEL_PRG_FIRST:   prg_first_d = item_i.bus_data;
            default:         prg_second_d = item_i.bus_data;
          endcase
        end
        REG_MIRROR: begin
          if (!cfg_i.four_screen) begin
            mirror_d = item_i.bus_data[0];
          end
        end
        REG_OUTER: begin
          outer_d = (item_i.bus_data[2:0] == OUTER_MAX) ? OUTER_CLAMP : item_i.bus_data[2:0];
        end
        REG_IRQ_COUNT: begin
          irq_cnt_d = item_i.bus_data;
        end
        REG_IRQ_RELOAD: begin
          irq_rel_d = item_i.bus_data;
        end
        REG_IRQ_OFF: begin
          irq_en_d   = 1'b0;
          irq_line_d = 1'b0;
        end
        default: begin
          irq_en_d = 1'b1;
        end
      endcase
    end
  end

  // window banks as seen after this transfer
  always_comb begin
    logic [7:0] fix_lo, fix_hi;
    logic [7:0] p [PrgSlots];
    bank_t      prg_base, chr_base;
    bank_t      lo [4];
    bank_t      hi [4];
    fix_lo   = (cfg_i.patch_mode && (outer_d != OUTER_PATCH_X)) ? FIX_PATCH : FIX_NORMAL;
    fix_hi   = fix_lo + 8'd1;
    prg_base = {3'b000, outer_d, 3'b000};
    chr_base = outer_d[1] ? CHR_HIGH_BASE : '0;
    if (mode_d[MODE_PRG_SWAP_BIT]) begin
      p[0] = fix_lo;
      p[2] = prg_first_d;
    end else begin
      p[0] = prg_first_d;
      p[2] = fix_lo;
    end
    p[1] = prg_second_d;
    p[3] = fix_hi;
    lo[0] = {1'b0, pair_d[0]};
    lo[1] = {1'b0, pair_d[0]} + 9'd1;
    lo[2] = {1'b0, pair_d[1]};
    lo[3] = {1'b0, pair_d[1]} + 9'd1;
    for (int i = 0; i < 4; i++) begin
      hi[i] = {1'b0, single_d[i]};
    end
    for (int i = 0; i < PrgSlots; i++) begin
      frame_o.bank[i] = prg_base + {1'b0, p[i]};
    end
    for (int i = 0; i < 4; i++) begin
      frame_o.bank[PrgSlots + i]     = chr_base + (mode_d[MODE_CHR_SWAP_BIT] ? hi[i] : lo[i]);
      frame_o.bank[PrgSlots + 4 + i] = chr_base + (mode_d[MODE_CHR_SWAP_BIT] ? lo[i] : hi[i]);
    end
    frame_o.mirror = mirror_d;
    frame_o.irq    = irq_line_d;
    frame_o.chr_on = cfg_i.chr_rom_present;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      outer_q      <= '0;
      prg_first_q  <= 8'd0;
      prg_second_q <= 8'd1;
      pair_q[0]    <= 8'd0;
      pair_q[1]    <= 8'd2;
      single_q[0]  <= 8'd4;
      single_q[1]  <= 8'd5;
      single_q[2]  <= 8'd6;
      single_q[3]  <= 8'd7;
      mirror_q     <= 1'b0;
      irq_en_q     <= 1'b0;
      irq_cnt_q    <= '0;
      irq_rel_q    <= '0;
      irq_line_q   <= 1'b0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      outer_q      <= outer_d;
      prg_first_q  <= prg_first_d;
      prg_second_q <= prg_second_d;
      pair_q       <= pair_d;
      single_q     <= single_d;
      mirror_q     <= mirror_d;
      irq_en_q     <= irq_en_d;
      irq_cnt_q    <= irq_cnt_d;
      irq_rel_q    <= irq_rel_d;
      irq_line_q   <= irq_line_d;
    end
  end

endmodule

### sv/mbm_emit.sv
// mbm_emit: result frame register and slot sequencer, one window bank per transfer
// depends on mbm_pkg; loaded from mbm_regs
module mbm_emit
  import mbm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  frame_t           frame_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [SlotW-1:0] slot_o,
  output bank_t            bank_number_o,
  output logic             mirror_mode_o,
  output logic             irq_out_o,
  output logic             last_o,
  output logic             done_o
);

  frame_t           frame_q;
  logic             valid_q;
  logic [SlotW-1:0] idx_q;
  logic             xfer;

  assign xfer          = valid_q && !out_stall_i;
  assign last_o        = frame_q.chr_on ? (idx_q == LAST_CHR_SLOT) : (idx_q == LAST_PRG_SLOT);
  assign done_o        = xfer && last_o;
  assign out_valid_o   = valid_q;
  assign slot_o        = idx_q;
  assign bank_number_o = frame_q.bank[idx_q];
  assign mirror_mode_o = frame_q.mirror;
  assign irq_out_o     = frame_q.irq;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (xfer) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + SlotW'(1);
      end
    end
  end

endmodule

### sv/multicart_bank_mapper_irq.sv
// multicart_bank_mapper_irq: top level with input register, config registers and assertions
// depends on mbm_pkg, mbm_regs and mbm_emit
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | cmd, bus_address, bus_data, line_counts
//  out     | output    | out_valid_o/out_stall_i| slot, bank_number, mirror_mode, irq_out, last
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// each item yields 12 results (4 with chr rom off), one per cycle from the frame register
// while out stall is low; an item waits in the input register and updates the mapper
// registers in the cycle the previous frame's last result transfers, or at once if no frame
// is pending; reset empties both stages and loads power-on banks
// out stall holds the current result; the input register holds one item while the frame drains
module multicart_bank_mapper_irq
  import mbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [15:0]          bus_address_i,
  input  logic [7:0]           bus_data_i,
  input  logic                 line_counts_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SlotW-1:0]     slot_o,
  output logic [BankW-1:0]     bank_number_o,
  output logic                 mirror_mode_o,
  output logic                 irq_out_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [0:0]           cfg_data_i
);

  item_t  item_q;
  logic   in_valid_q;
  cfg_t   cfg_q;
  frame_t frame;
  logic   advance;
  logic   done;

  assign advance    = in_valid_q && (!out_valid_o || done);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{cmd: cmd_i, bus_address: bus_address_i, bus_data: bus_data_i,
                  line_counts: line_counts_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{patch_mode: 1'b0, chr_rom_present: 1'b1, four_screen: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATCH_MODE: cfg_q.patch_mode      <= cfg_data_i[0];
        CFG_CHR_ROM:    cfg_q.chr_rom_present <= cfg_data_i[0];
        CFG_FOUR_SCR:   cfg_q.four_screen     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .frame_o (frame)
  );

  mbm_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .frame_i       (frame),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .slot_o        (slot_o),
    .bank_number_o (bank_number_o),
    .mirror_mode_o (mirror_mode_o),
    .irq_out_o     (irq_out_o),
    .last_o        (last_o),
    .done_o        (done)
  );

  // a run never has a gap before its last result
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("result run broken before last transfer");

  // a waiting item starts its run right after the previous run ends
  a_next_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o && in_valid_q |=> out_valid_o && slot_o == '0)
    else $error("queued item did not start at slot zero");

  // a run ends on the last prg or last chr window
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> slot_o == LAST_PRG_SLOT || slot_o == LAST_CHR_SLOT)
    else $error("last flag on a middle slot");

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for multicart_bank_mapper_irq with its own window bank predictor
// depends on mbm_pkg and the multicart_bank_mapper_irq rtl; bursty sender, patterned receiver
`timescale 1ns / 100ps

module testbench;
  import mbm_pkg::*;

  typedef struct {
    logic [SlotW-1:0] slot;
    bank_t            bank;
    logic             mirror;
    logic             irq;
    logic             last;
  } window_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i = CMD_WRITE;
  logic [15:0]          bus_address_i = '0;
  logic [7:0]           bus_data_i = '0;
  logic                 line_counts_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SlotW-1:0]     slot_o;
  logic [BankW-1:0]     bank_number_o;
  logic                 mirror_mode_o;
  logic                 irq_out_o;
  logic                 last_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [0:0]           cfg_data_i = '0;

  multicart_bank_mapper_irq dut (.*);

  always #4 clk_i = ~clk_i;

  // predicted mapper state and configuration
  logic       p_patch = 1'b0;
  logic       p_chr_rom = 1'b1;
  logic       p_four_scr = 1'b0;
  logic [7:0] p_mode = 8'd0;
  logic [2:0] p_outer = 3'd0;
  logic [7:0] p_prg_first = 8'd0;
  logic [7:0] p_prg_second = 8'd1;
  logic [7:0] p_chr_pair [2] = '{8'd0, 8'd2};
  logic [7:0] p_chr_single [4] = '{8'd4, 8'd5, 8'd6, 8'd7};
  logic       p_mirror = 1'b0;
  logic       p_irq_en = 1'b0;
  logic [7:0] p_irq_cnt = 8'd0;
  logic [7:0] p_irq_reload = 8'd0;
  logic       p_irq_line = 1'b0;

  item_t       bus_events [$];
  window_t     due_windows [$];
  int unsigned queued_count = 0;
  int unsigned taken_count = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned pattern_left = 0;
  int unsigned stall_mode = 0;

  task automatic map_item(input item_t it);
    logic [7:0] fix_lo;
    logic [7:0] prg [4];
    logic [7:0] lo [4];
    logic [7:0] chr [8];
    bank_t      prg_base;
    bank_t      chr_base;
    window_t    w;
    int         total;
    if (it.cmd == CMD_TICK) begin
      if (it.line_counts && p_irq_en) begin
        p_irq_cnt = p_irq_cnt - 8'd1;
        if (p_irq_cnt == 8'd0) begin
          p_irq_cnt = p_irq_reload;
          p_irq_line = 1'b1;
        end
      end
    end else if (it.bus_address < REG_MODE) begin
      if (it.bus_address == OUTER_ADDR) begin
        p_outer = p_patch ? {1'b0, it.bus_data[2:1]} : {1'b0, it.bus_data[0], 1'b0};
      end
    end else begin
      case (it.bus_address & ADDR_MASK)
        REG_MODE: p_mode = it.bus_data;
        REG_BANK_DATA: begin
          case (bank_sel_e'(p_mode[2:0]))
            SEL_CHR_PAIR0:   p_chr_pair[0] = it.bus_data & 8'hFE;
            SEL_CHR_PAIR1:   p_chr_pair[1] = it.bus_data & 8'hFE;
            SEL_CHR_SINGLE0: p_chr_single[0] = it.bus_data;
            SEL_CHR_SINGLE1: p_chr_single[1] = it.bus_data;
            SEL_CHR_SINGLE2: p_chr_single[2] = it.bus_data;
            SEL_CHR_SINGLE3: p_chr_single[3] = it.bus_data;
            SEL_PRG_FIRST:   p_prg_first = it.bus_data;
            default:         p_prg_second = it.bus_data;
          endcase
        end
        REG_MIRROR: begin
          if (!p_four_scr) p_mirror = it.bus_data[0];
        end
        REG_OUTER: p_outer = (it.bus_data[2:0] == OUTER_MAX) ? OUTER_CLAMP : it.bus_data[2:0];
        REG_IRQ_COUNT: p_irq_cnt = it.bus_data;
        REG_IRQ_RELOAD: p_irq_reload = it.bus_data;
        REG_IRQ_OFF: begin
          p_irq_en = 1'b0;
          p_irq_line = 1'b0;
        end
        default: p_irq_en = 1'b1;
      endcase
    end

    fix_lo = (p_patch && p_outer != OUTER_PATCH_X) ? FIX_PATCH : FIX_NORMAL;
    if (p_mode[MODE_PRG_SWAP_BIT]) begin
      prg = '{fix_lo, p_prg_second, p_prg_first, fix_lo + 8'd1};
    end else begin
      prg = '{p_prg_first, p_prg_second, fix_lo, fix_lo + 8'd1};
    end
    lo = '{p_chr_pair[0], p_chr_pair[0] + 8'd1, p_chr_pair[1], p_chr_pair[1] + 8'd1};
    for (int i = 0; i < 4; i++) begin
      chr[i]     = p_mode[MODE_CHR_SWAP_BIT] ? p_chr_single[i] : lo[i];
      chr[i + 4] = p_mode[MODE_CHR_SWAP_BIT] ? lo[i] : p_chr_single[i];
    end
    prg_base = {3'b000, p_outer, 3'b000};
    chr_base = p_outer[1] ? CHR_HIGH_BASE : '0;
    total = p_chr_rom ? NumSlots : PrgSlots;
    for (int i = 0; i < total; i++) begin
      w.slot   = SlotW'(i);
      w.bank   = (i < PrgSlots) ? prg_base + {1'b0, prg[i]} : chr_base + {1'b0, chr[i - 4]};
      w.mirror = p_mirror;
      w.irq    = p_irq_line;
      w.last   = (i == total - 1);
      due_windows.push_back(w);
    end
  endtask

  // sender: acceptance at the rising edge, next item at the falling edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      map_item('{cmd: cmd_i, bus_address: bus_address_i, bus_data: bus_data_i,
                 line_counts: line_counts_i});
      taken_count++;
    end
  end

  always @(negedge clk_i) begin
    item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (bus_events.size() != 0) begin
        it = bus_events.pop_front();
        cmd_i         <= it.cmd;
        bus_address_i <= it.bus_address;
        bus_data_i    <= it.bus_data;
        line_counts_i <= it.line_counts;
        in_valid_i    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
          gap_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(40, 160);
      stall_mode = $urandom_range(0, 2);
    end else begin
      pattern_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    window_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_windows.size() == 0) begin
        $error("result transfer with nothing expected: slot %0d bank %0d",
               slot_o, bank_number_o);
        err_count++;
      end else begin
        w = due_windows.pop_front();
        check_field("slot", 9'(w.slot), 9'(slot_o));
        check_field("bank_number", w.bank, bank_number_o);
        check_field("mirror_mode", 9'(w.mirror), 9'(mirror_mode_o));
        check_field("irq_out", 9'(w.irq), 9'(irq_out_o));
        check_field("last", 9'(w.last), 9'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 2000) begin
      $error("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input item_t it);
    bus_events.push_back(it);
    queued_count++;
  endtask

  task automatic add_write(input logic [15:0] addr, input logic [7:0] data);
    add_item('{cmd: CMD_WRITE, bus_address: addr, bus_data: data,
               line_counts: 1'($urandom)});
  endtask

  task automatic add_tick(input logic counts);
    add_item('{cmd: CMD_TICK, bus_address: 16'($urandom), bus_data: 8'($urandom),
               line_counts: counts});
  endtask

  function automatic logic [15:0] reg_addr(input logic [15:0] r);
    return (16'($urandom) & ~ADDR_MASK) | r;
  endfunction

  function automatic logic [7:0] irq_value();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
  endfunction

  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PATCH_MODE: p_patch = val;
      CFG_CHR_ROM:    p_chr_rom = val;
      default:        p_four_scr = val;
    endcase
  endtask

  task automatic set_cfg(input logic patch, input logic chr_rom, input logic four_scr);
    write_cfg(CFG_PATCH_MODE, patch);
    write_cfg(CFG_CHR_ROM, chr_rom);
    write_cfg(CFG_FOUR_SCR, four_scr);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (taken_count != queued_count || due_windows.size() != 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic add_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    item_t       it;
    start = queued_count;
    while (queued_count - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_write(reg_addr(REG_MODE), 8'($urandom));
        add_write(reg_addr(REG_BANK_DATA), 8'($urandom));
      end else if (pick < 42) begin
        add_write(reg_addr(REG_IRQ_COUNT), irq_value());
        add_write(reg_addr(REG_IRQ_RELOAD), irq_value());
        add_write(reg_addr(REG_IRQ_ON), 8'($urandom));
        repeat ($urandom_range(2, 10)) add_tick($urandom_range(0, 7) != 0);
      end else if (pick < 60) begin
        add_tick($urandom_range(0, 3) != 0);
      end else if (pick < 70) begin
        if ($urandom_range(0, 1)) add_write(OUTER_ADDR, 8'($urandom));
        else add_write(reg_addr(REG_OUTER), 8'($urandom));
      end else if (pick < 80) begin
        add_write(reg_addr($urandom_range(0, 1) ? REG_MIRROR : REG_IRQ_OFF), 8'($urandom));
      end else if (pick < 86) begin
        add_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      end else begin
        it = '{cmd: 1'($urandom), bus_address: 16'($urandom), bus_data: 8'($urandom),
               line_counts: 1'($urandom)};
        add_item(it);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_cfg(1'b0, 1'b1, 1'b0);
    add_write(16'h5FFF, 8'hFF);
    add_write(OUTER_ADDR, 8'hFF);
    add_write(REG_MODE, 8'hC6);
    add_write(REG_BANK_DATA, 8'hFF);
    add_write(REG_MODE, 8'h07);
    add_write(REG_BANK_DATA, 8'h00);
    add_write(REG_MODE, 8'h00);
    add_write(REG_BANK_DATA, 8'hFF);
    add_write(REG_MODE, 8'h01);
    add_write(REG_BANK_DATA, 8'h81);
    add_write(REG_OUTER | 16'h1FFE, 8'hFF);
    add_write(REG_MIRROR, 8'h01);
    add_write(REG_IRQ_COUNT, 8'h00);
    add_write(REG_IRQ_RELOAD, 8'hFF);
    add_write(16'hFFFF, 8'h00);
    add_tick(1'b1);
    add_tick(1'b0);
    add_write(REG_IRQ_COUNT, 8'h01);
    add_tick(1'b1);
    add_write(REG_IRQ_OFF, 8'h00);
    add_write(16'h0000, 8'h00);
    wait_idle();

    // patch decoding, outer bank 2 exception, mirroring ignored on four-screen
    set_cfg(1'b1, 1'b1, 1'b1);
    add_write(OUTER_ADDR, 8'h04);
    add_write(OUTER_ADDR, 8'h02);
    add_write(REG_MIRROR, 8'h00);
    add_write(REG_OUTER, 8'h02);
    add_random_traffic(80);
    wait_idle();

    set_cfg(1'b1, 1'b0, 1'b0);
    hold_req = 1'b1;
    add_random_traffic(80);
    wait_idle();

    set_cfg(1'b0, 1'b0, 1'b1);
    add_random_traffic(80);
    wait_idle();

    set_cfg(1'b1, 1'b0, 1'b1);
    add_random_traffic(80);
    wait_idle();

    set_cfg(1'b0, 1'b1, 1'b0);
    add_random_traffic(85);
    wait_idle();

    if (err_count == 0 && due_windows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mbm_pkg.sv
sv/mbm_regs.sv
sv/mbm_emit.sv
sv/multicart_bank_mapper_irq.sv
tb/sv/testbench.sv
